/* rtl/core/sacfl_pkg.sv */
// Shared command and status types for the set-associative FIFO cache lookup.
`default_nettype none

package sacfl_pkg;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear_wr;  // write one cleared row of valid bits and fill pointer
    logic load;      // capture a new address
    logic div_step;  // one step of the set-index remainder
    logic read;      // read tags, valid bits and fill pointer of the set
    logic commit;    // present the result and update the set on a miss
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;  // the clearing pass is on its last row
    logic div_last;    // the remainder is on its last step
  } status_t;

endpackage

`default_nettype wire

/* rtl/core/sacfl_ctrl.sv */
// Controller state machine for the set-associative FIFO cache lookup.
`default_nettype none

module sacfl_ctrl #(
  parameter bit USE_DIV = 1'b0
) (
  input  wire              clk,
  input  wire              rst,
  input  wire              req_valid,
  output logic             req_stall,
  output logic             rsp_valid,
  input  wire              rsp_stall,
  output sacfl_pkg::cmd_t  cmd,
  input  sacfl_pkg::status_t st
);
  import sacfl_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_READ,
    S_CMP
  } state_t;

  state_t state;
  logic   accept;
  logic   out_free;

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && (state == S_IDLE);
  assign out_free  = !rsp_valid || !rsp_stall;

  always_comb begin
    cmd          = '0;
    cmd.clear_wr = (state == S_CLEAR);
    cmd.load     = accept;
    cmd.div_step = (state == S_DIV);
    cmd.read     = (state == S_READ);
    cmd.commit   = (state == S_CMP) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      rsp_valid <= 1'b0;
    end else begin
      if (cmd.commit) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          if (st.clear_last) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            state <= USE_DIV ? S_DIV : S_READ;
          end
        end
        S_DIV: begin
          if (st.div_last) begin
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_CMP;
        end
        S_CMP: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/core/sacfl_dpath.sv */
// Datapath: set index, tag and state memories, way compare and replacement choice.
`default_nettype none

module sacfl_dpath #(
  parameter int SETS      = 64,
  parameter int WAYS      = 4,
  parameter int ADDR_BITS = 32
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire  [31:0]         address,
  input  sacfl_pkg::cmd_t     cmd,
  output sacfl_pkg::status_t  st,
  output logic                hit,
  output logic [1:0]          way
);
  import sacfl_pkg::*;

  localparam int AW    = (ADDR_BITS < 32) ? ADDR_BITS : 32;
  localparam int SHIFT = $clog2(SETS + 1) - 1;
  localparam bit POW2  = (SETS == (1 << SHIFT));
  localparam int SET_W = $clog2(SETS);
  localparam int TAG_W = AW - SHIFT;
  localparam int PTR_W = (WAYS > 1) ? $clog2(WAYS) : 1;

  logic [SET_W-1:0] rem;
  logic [TAG_W-1:0] tag_q;
  logic [SET_W-1:0] clr_idx;

  logic [WAYS-1:0]  vld_mem [SETS];
  logic [PTR_W-1:0] ptr_mem [SETS];
  logic [WAYS-1:0]  vld_q;
  logic [PTR_W-1:0] ptr_q;
  logic [TAG_W-1:0] tag_rd [WAYS];

  logic             hit_c;
  logic [PTR_W-1:0] hit_way;
  logic [PTR_W-1:0] inv_way;
  logic [PTR_W-1:0] victim;
  logic [PTR_W-1:0] ptr_next;
  logic [WAYS-1:0]  vld_new;

  assign st.clear_last = (clr_idx == SET_W'(SETS - 1));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      tag_q <= address[AW-1:SHIFT];
    end
  end

  // Set index: a bit slice for a power-of-two set count, else a reciprocal
  // estimate of the quotient followed by a subtraction and one correction.
  generate
    if (POW2) begin : g_slice
      assign st.div_last = 1'b1;
      always_ff @(posedge clk) begin
        if (cmd.load) begin
          rem <= address[SET_W-1:0];
        end
      end
    end else begin : g_rem
      // The estimate is never more than one below the true quotient, so the
      // raw remainder lies below twice the set count.
      localparam int          DIV_STEPS = 3;
      localparam logic [31:0] RECIP     = 32'((64'd1 << (32 + SHIFT)) / 64'(SETS));
      logic [31:0]    areg;
      logic [1:0]     cnt;
      logic [SET_W:0] q_q;
      logic [SET_W:0] qs_low;
      logic [SET_W:0] r_est;

      assign qs_low      = q_q * (SET_W + 1)'(SETS);
      assign st.div_last = (cnt == 2'(DIV_STEPS - 1));

      always_ff @(posedge clk) begin
        if (cmd.load) begin
          areg <= 32'(address[AW-1:0]);
          cnt  <= '0;
        end else if (cmd.div_step) begin
          cnt   <= cnt + 1'b1;
          q_q   <= (SET_W + 1)'((64'(areg) * 64'(RECIP)) >> (32 + SHIFT));
          r_est <= areg[SET_W:0] - qs_low;
          if (r_est >= (SET_W + 1)'(SETS)) begin
            rem <= SET_W'(r_est - (SET_W + 1)'(SETS));
          end else begin
            rem <= r_est[SET_W-1:0];
          end
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
    end else if (cmd.clear_wr) begin
      clr_idx <= clr_idx + 1'b1;
    end
  end

  // Valid bits and fill pointer share one write port with the clearing pass.
  always_ff @(posedge clk) begin
    if (cmd.clear_wr) begin
      vld_mem[clr_idx] <= '0;
      ptr_mem[clr_idx] <= '0;
    end else if (cmd.commit && !hit_c) begin
      vld_mem[rem] <= vld_new;
      ptr_mem[rem] <= ptr_next;
    end
    if (cmd.read) begin
      vld_q <= vld_mem[rem];
      ptr_q <= ptr_mem[rem];
    end
  end

  generate
    for (genvar w = 0; w < WAYS; w++) begin : g_way
      logic [TAG_W-1:0] mem [SETS];
      logic [TAG_W-1:0] rd_q;
      always_ff @(posedge clk) begin
        if (cmd.commit && !hit_c && (victim == PTR_W'(w))) begin
          mem[rem] <= tag_q;
        end
        if (cmd.read) begin
          rd_q <= mem[rem];
        end
      end
      assign tag_rd[w] = rd_q;
    end
  endgenerate

  always_comb begin
    hit_c   = 1'b0;
    hit_way = '0;
    inv_way = '0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (vld_q[i] && (tag_rd[i] == tag_q)) begin
        hit_c   = 1'b1;
        hit_way = PTR_W'(i);
      end
      if (!vld_q[i]) begin
        inv_way = PTR_W'(i);
      end
    end
  end

  assign victim   = (&vld_q) ? ptr_q : inv_way;
  assign ptr_next = (ptr_q == PTR_W'(WAYS - 1)) ? '0 : ptr_q + 1'b1;
  assign vld_new  = vld_q | (WAYS'(1) << victim);

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      hit <= hit_c;
      way <= hit_c ? 2'(hit_way) : 2'(victim);
    end
  end

endmodule

`default_nettype wire

/* rtl/core/set_assoc_cache_fifo_lookup.sv */
// Top level of the set-associative cache lookup with FIFO replacement.
`default_nettype none

// Channel   Handshake             Payload
// request   req_valid/req_stall   address[31:0]
// response  rsp_valid/rsp_stall   hit, way[1:0]
//
// When SETS is a power of two a transaction goes through accept, read of the
// set's tags, valid bits and fill pointer, then compare and update. For any
// other SETS the set index comes from a reciprocal multiplication, a subtraction
// and one corrective compare, done in a divide state between accept and read.
// After reset a clearing pass writes one set's valid bits and fill pointer per
// cycle until every set is cleared; req_stall stays high until it ends.
// A finished result waits in the output register, so a stalled response does
// not hold up the next request until that request has its own result ready.

module set_assoc_cache_fifo_lookup #(
  parameter int SETS      = 64,
  parameter int WAYS      = 4,
  parameter int ADDR_BITS = 32
) (
  input  wire        clk,
  input  wire        rst,
  input  wire        req_valid,
  output logic       req_stall,
  input  wire [31:0] address,
  output logic       rsp_valid,
  input  wire        rsp_stall,
  output logic       hit,
  output logic [1:0] way
);
  import sacfl_pkg::*;

  // The remainder unit is only needed when the set count is not a power of two.
  localparam bit USE_DIV = (SETS != (1 << ($clog2(SETS + 1) - 1)));

  cmd_t    cmd;
  status_t st;

  // The controller sequences each transaction and owns the response valid flag.
  sacfl_ctrl #(
    .USE_DIV (USE_DIV)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .cmd       (cmd),
    .st        (st)
  );

  // The datapath holds the tag memories, the valid and fill pointer memories,
  // the parallel way compare and the result register.
  sacfl_dpath #(
    .SETS      (SETS),
    .WAYS      (WAYS),
    .ADDR_BITS (ADDR_BITS)
  ) u_dpath (
    .clk     (clk),
    .rst     (rst),
    .address (address),
    .cmd     (cmd),
    .st      (st),
    .hit     (hit),
    .way     (way)
  );

endmodule

`default_nettype wire

/* test/sacfl_lookup_checker.sv */
// Scoreboard for the cache lookup: models tags, valid bits and fill pointers, checks responses.
`timescale 1ns / 100ps

module sacfl_lookup_checker #(
  parameter int SETS      = 64,
  parameter int WAYS      = 4,
  parameter int ADDR_BITS = 32
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         req_valid,
  input  wire         req_stall,
  input  wire  [31:0] address,
  input  wire         rsp_valid,
  input  wire         rsp_stall,
  input  wire         hit,
  input  wire  [1:0]  way,
  output int unsigned mismatch_count,
  output int unsigned outstanding
);

  // The tag is the address shifted by the floor of log2 of the set count.
  function automatic int floor_log2(input int n);
    int s;
    s = 0;
    while (n > 1) begin
      n = n >> 1;
      s++;
    end
    return s;
  endfunction

  localparam int TAG_SHIFT = floor_log2(SETS);

  typedef struct packed {
    logic [31:0] addr;
    logic        hit;
    logic [1:0]  way;
  } lookup_t;

  logic [63:0] line_tag   [WAYS][SETS];
  logic        line_valid [WAYS][SETS];
  int unsigned next_victim [SETS];
  lookup_t     expected_lookups [$];
  lookup_t     predicted;
  lookup_t     oldest;

  // Looks the address up in the shadow cache and fills a way on a miss.
  task automatic look_up(input logic [31:0] addr_in, output lookup_t res);
    logic [63:0] a;
    logic [63:0] tag;
    int          set_idx;
    int          victim;
    bit          found;
    a = {32'd0, addr_in};
    if (ADDR_BITS < 64) a = a & ((64'd1 << ADDR_BITS) - 64'd1);
    set_idx  = int'(a % 64'(SETS));
    tag      = a >> TAG_SHIFT;
    res.addr = addr_in;
    res.hit  = 1'b0;
    res.way  = 2'd0;
    found    = 1'b0;
    for (int w = 0; w < WAYS; w++) begin
      if (!found && line_valid[w][set_idx] && line_tag[w][set_idx] == tag) begin
        found   = 1'b1;
        res.hit = 1'b1;
        res.way = 2'(w);
      end
    end
    if (!found) begin
      // Lowest invalid way first, otherwise the way filled longest ago.
      victim = -1;
      for (int w = WAYS - 1; w >= 0; w--) begin
        if (!line_valid[w][set_idx]) victim = w;
      end
      if (victim < 0) victim = int'(next_victim[set_idx]);
      line_tag[victim][set_idx]   = tag;
      line_valid[victim][set_idx] = 1'b1;
      next_victim[set_idx]        = (next_victim[set_idx] + 1) % WAYS;
      res.way = 2'(victim);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int w = 0; w < WAYS; w++) begin
        for (int s = 0; s < SETS; s++) begin
          line_tag[w][s]   = '0;
          line_valid[w][s] = 1'b0;
        end
      end
      for (int s = 0; s < SETS; s++) next_victim[s] = 0;
      expected_lookups.delete();
      mismatch_count = 0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (expected_lookups.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("Mismatch at %0t: response hit=%0d way=%0d with no lookup outstanding",
                     $time, hit, way);
        end else begin
          oldest = expected_lookups.pop_front();
          if (hit !== oldest.hit || way !== oldest.way) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("Mismatch at %0t: address %h expected hit=%0d way=%0d, got hit=%0d way=%0d",
                       $time, oldest.addr, oldest.hit, oldest.way, hit, way);
          end
        end
      end
      if (req_valid && !req_stall) begin
        look_up(address, predicted);
        expected_lookups.push_back(predicted);
      end
    end
    outstanding = expected_lookups.size();
  end

endmodule

/* test/tb.sv */
// Top-level testbench for the set-associative cache lookup with FIFO replacement.
`timescale 1ns / 100ps

module tb;

  localparam int SETS         = 64;
  localparam int WAYS         = 4;
  localparam int ADDR_BITS    = 32;
  localparam int RANDOM_ITEMS = 1600;
  // The receiver holds off once, after this many responses, for this many cycles.
  localparam int HOLD_AFTER   = 500;
  localparam int HOLD_CYCLES  = 200;
  // The sender stops and lets the pipeline drain once, at this random item.
  localparam int DRAIN_AT     = 1000;

  logic        clk;
  logic        rst       = 1'b1;
  logic        req_valid = 1'b0;
  logic [31:0] address   = '0;
  logic        rsp_stall = 1'b0;
  logic        req_stall;
  logic        rsp_valid;
  logic        hit;
  logic [1:0]  way;

  int unsigned mismatch_count;
  int unsigned outstanding;

  // A small pool of tags shared by all sets, so that random traffic gives hits, fills
  // of invalid ways and FIFO evictions of full sets rather than only misses.
  logic [25:0] tag_pool [6];
  bit          send_burst;

  set_assoc_cache_fifo_lookup #(
    .SETS      (SETS),
    .WAYS      (WAYS),
    .ADDR_BITS (ADDR_BITS)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .address   (address),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .hit       (hit),
    .way       (way)
  );

  sacfl_lookup_checker #(
    .SETS      (SETS),
    .WAYS      (WAYS),
    .ADDR_BITS (ADDR_BITS)
  ) lookup_checker (
    .clk            (clk),
    .rst            (rst),
    .req_valid      (req_valid),
    .req_stall      (req_stall),
    .address        (address),
    .rsp_valid      (rsp_valid),
    .rsp_stall      (rsp_stall),
    .hit            (hit),
    .way            (way),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The run can never legitimately take this long: about 1600 transactions with
  // their random idle gaps on both sides, the long hold-off and the clearing
  // pass after reset come to far less, which leaves a wide margin.
  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

  // Offers one address on the request channel. A random number of idle cycles
  // goes first unless the sender is in a burst stretch; valid then stays high
  // and the address steady until the block accepts the transaction.
  task automatic offer(input logic [31:0] a);
    int gap;
    gap = send_burst ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    address   <= a;
    do @(posedge clk); while (req_stall);
  endtask

  // Random addresses: most use a pooled tag in a random set, a share of those
  // crowd into the first four sets to force repeated eviction, and the rest
  // are fully random so that every address bit is exercised both ways.
  function automatic logic [31:0] random_address();
    int          pick;
    logic [5:0]  set_idx;
    pick = $urandom_range(0, 9);
    if (pick < 3) return $urandom();
    set_idx = (pick < 5) ? 6'($urandom_range(0, 3)) : 6'($urandom_range(0, SETS - 1));
    return {tag_pool[$urandom_range(0, 5)], set_idx};
  endfunction

  // Receiver: stalls for a randomly drawn hold before each response, except in
  // burst stretches, and once holds off for a long time so that the block
  // fills up and pushes back on the request side.
  initial begin
    int  taken;
    int  hold;
    bit  recv_burst;
    taken      = 0;
    recv_burst = 1'b0;
    forever begin
      if (taken % 64 == 0) recv_burst = ($urandom_range(0, 3) == 0);
      if (taken == HOLD_AFTER) hold = HOLD_CYCLES;
      else hold = recv_burst ? 0 : $urandom_range(0, 3);
      if (hold > 0) begin
        rsp_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        rsp_stall <= 1'b0;
      end
      do @(posedge clk); while (!rsp_valid);
      taken++;
    end
  end

  // Sender and verdict.
  initial begin
    logic [31:0] directed [$];

    tag_pool[0] = '0;
    tag_pool[1] = '1;
    for (int i = 2; i < 6; i++) tag_pool[i] = 26'($urandom());
    send_burst = 1'b0;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed part. Tag zero with a cleared valid bit must still miss. Set 5
    // is filled through all four ways, overflowed so that way 0 (the oldest)
    // is evicted, hit on every way, and then overflowed twice more to check
    // that the replacement order is FIFO.
    directed = '{32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                 32'h0000_0045, 32'h0000_0085, 32'h0000_00C5, 32'h0000_0105,
                 32'h0000_0145,
                 32'h0000_0085, 32'h0000_00C5, 32'h0000_0105, 32'h0000_0145,
                 32'h0000_0045, 32'h0000_0085,
                 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h8000_0000,
                 32'h0000_003F, 32'h0000_0001};
    foreach (directed[i]) offer(directed[i]);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 50 == 0) send_burst = ($urandom_range(0, 3) == 0);
      // Let every outstanding transaction come back before going on, so the
      // block restarts from an empty pipeline.
      if (n == DRAIN_AT) begin
        req_valid <= 1'b0;
        do @(negedge clk); while (outstanding != 0);
        @(posedge clk);
      end
      offer(random_address());
    end
    req_valid <= 1'b0;

    // Wait for the last responses, then wait on to catch any stray
    // response the block might still produce.
    do @(negedge clk); while (outstanding != 0);
    repeat (20) @(posedge clk);

    if (mismatch_count == 0 && outstanding == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
